// File: rtl/q2e_pkg.sv
// Shared types, widths, latency figures and the arctangent table for the
// quaternion to Euler angle converter. Depends on nothing.
package q2e_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int CORDIC_ITER   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  localparam int QW       = 16;   // quaternion component width
  localparam int PRW      = 32;   // 16 x 16 product width
  localparam int SW       = 34;   // width of the doubled sums
  localparam int CW       = 37;   // CORDIC x and y width, allows for gain and the half turn
  localparam int AW       = 34;   // CORDIC angle width, 2^-23 degree units
  localparam int SQ_STEPS = 29;   // one result bit of the square root per stage
  localparam int SQ_W     = 58;

  // Register stages in front of the CORDIC, and in total.
  localparam int FRONT = 4 + SQ_STEPS;
  localparam int DLY   = 2 + SQ_STEPS;
  localparam int LAT   = FRONT + 1 + CORDIC_ITER + 1;

  localparam int ROLL_LIM  = 23040;
  localparam int PITCH_LIM = 11520;

  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [CW-1:0] cv_t;
  typedef logic signed [AW-1:0] ang_t;

  localparam ang_t ANG_180 = 34'sd1509949440;

  // atan(2^-i) in units of 2^-23 degree, rounded to nearest.
  localparam logic [29:0] ATAN_TAB [TABLE_LEN] = '{
    30'd377487360, 30'd222843801, 30'd117744544, 30'd59768969, 30'd30000467,
    30'd15014858, 30'd7509261, 30'd3754860, 30'd1877459, 30'd938733,
    30'd469367, 30'd234683, 30'd117342, 30'd58671, 30'd29335, 30'd14668,
    30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229, 30'd115, 30'd57
  };

endpackage

// File: rtl/q2e_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in 2^-23 degree units.
// Depends on q2e_pkg for widths, stage count and the arctangent table.
module q2e_cordic (
  input  logic           clk,
  input  logic           en,
  input  q2e_pkg::sum_t  y_in,
  input  q2e_pkg::sum_t  x_in,
  output q2e_pkg::ang_t  ang
);

  q2e_pkg::cv_t  cx    [0:q2e_pkg::CORDIC_ITER];
  q2e_pkg::cv_t  cy    [0:q2e_pkg::CORDIC_ITER];
  q2e_pkg::ang_t cz    [0:q2e_pkg::CORDIC_ITER];
  logic          czero [0:q2e_pkg::CORDIC_ITER];

  // A vector in the left half plane is turned through half a turn first.
  always_ff @(posedge clk) begin
    if (en) begin
      czero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        cx[0] <= -q2e_pkg::cv_t'(x_in);
        cy[0] <= -q2e_pkg::cv_t'(y_in);
        cz[0] <= (y_in >= 0) ? q2e_pkg::ANG_180 : -q2e_pkg::ANG_180;
      end else begin
        cx[0] <= q2e_pkg::cv_t'(x_in);
        cy[0] <= q2e_pkg::cv_t'(y_in);
        cz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < q2e_pkg::CORDIC_ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        czero[i+1] <= czero[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + q2e_pkg::ang_t'(q2e_pkg::ATAN_TAB[i]);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - q2e_pkg::ang_t'(q2e_pkg::ATAN_TAB[i]);
        end
      end
    end
  end

  assign ang = czero[q2e_pkg::CORDIC_ITER] ? '0 : cz[q2e_pkg::CORDIC_ITER];

endmodule

// File: rtl/quaternion_to_euler_degrees.sv
// Quaternion to ZYX Euler angles. The pipeline holds four arithmetic stages,
// 29 square-root stages, the CORDIC half-turn stage, the CORDIC iterations and
// the output register.
// Throughput is one word per cycle; the whole pipeline holds while a result waits.
// Reset (rst, synchronous) clears the valid bits only. Uses q2e_pkg and q2e_cordic.
module quaternion_to_euler_degrees (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] roll_deg,
  output logic signed [14:0] pitch_deg,
  output logic signed [15:0] yaw_deg
);

  // The pipeline moves as one: it advances whenever the output register is
  // empty or its word is being taken. Valid bits travel alongside the data.
  logic en;
  logic vpipe [0:q2e_pkg::LAT-1];

  assign en        = !vpipe[q2e_pkg::LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vpipe[q2e_pkg::LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < q2e_pkg::LAT; k++) vpipe[k] <= 1'b0;
    end else if (en) begin
      vpipe[0] <= in_valid;
      for (int k = 1; k < q2e_pkg::LAT; k++) vpipe[k] <= vpipe[k-1];
    end
  end

  // Stage one: the nine products of the components.
  logic signed [q2e_pkg::PRW-1:0] pwx, pyz, pwz, pxy, pxx, pyy, pzz, pwy, pzx;

  always_ff @(posedge clk) begin
    if (en) begin
      pwx <= quat_w * quat_x;
      pyz <= quat_y * quat_z;
      pwz <= quat_w * quat_z;
      pxy <= quat_x * quat_y;
      pxx <= quat_x * quat_x;
      pyy <= quat_y * quat_y;
      pzz <= quat_z * quat_z;
      pwy <= quat_w * quat_y;
      pzx <= quat_z * quat_x;
    end
  end

  // Stage two: the doubled sums in Q.28, with the asin argument clamped to
  // plus or minus one.
  q2e_pkg::sum_t rn_c, rd_c, yn_c, yd_c, s_raw;
  logic signed [29:0] s_c;

  always_comb begin
    rn_c  = (q2e_pkg::sum_t'(pwx) + q2e_pkg::sum_t'(pyz)) <<< 1;
    rd_c  = q2e_pkg::sum_t'(1 <<< 28) - ((q2e_pkg::sum_t'(pxx) + q2e_pkg::sum_t'(pyy)) <<< 1);
    yn_c  = (q2e_pkg::sum_t'(pwz) + q2e_pkg::sum_t'(pxy)) <<< 1;
    yd_c  = q2e_pkg::sum_t'(1 <<< 28) - ((q2e_pkg::sum_t'(pyy) + q2e_pkg::sum_t'(pzz)) <<< 1);
    s_raw = (q2e_pkg::sum_t'(pwy) - q2e_pkg::sum_t'(pzx)) <<< 1;
    if (s_raw > q2e_pkg::sum_t'(1 <<< 28)) begin
      s_c = 30'sd268435456;
    end else if (s_raw < -q2e_pkg::sum_t'(1 <<< 28)) begin
      s_c = -30'sd268435456;
    end else begin
      s_c = s_raw[29:0];
    end
  end

  // Roll, yaw and the asin argument wait in delay lines while the square
  // root is worked out; index zero is the stage-two register.
  q2e_pkg::sum_t      d_rn [0:q2e_pkg::DLY];
  q2e_pkg::sum_t      d_rd [0:q2e_pkg::DLY];
  q2e_pkg::sum_t      d_yn [0:q2e_pkg::DLY];
  q2e_pkg::sum_t      d_yd [0:q2e_pkg::DLY];
  logic signed [29:0] s_d  [0:q2e_pkg::DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      d_rn[0] <= rn_c;
      d_rd[0] <= rd_c;
      d_yn[0] <= yn_c;
      d_yd[0] <= yd_c;
      s_d[0]  <= s_c;
      for (int k = 0; k < q2e_pkg::DLY; k++) begin
        d_rn[k+1] <= d_rn[k];
        d_rd[k+1] <= d_rd[k];
        d_yn[k+1] <= d_yn[k];
        d_yd[k+1] <= d_yd[k];
        s_d[k+1]  <= s_d[k];
      end
    end
  end

  // Stage three squares the magnitude of s; stage four forms 1 - s^2 in Q.56.
  logic [28:0]             s_abs;
  logic [57:0]             s2;
  logic [q2e_pkg::SQ_W-1:0] sq_n   [0:q2e_pkg::SQ_STEPS];
  logic [q2e_pkg::SQ_W-1:0] sq_res [0:q2e_pkg::SQ_STEPS];

  assign s_abs = s_d[0][29] ? 29'(-s_d[0]) : s_d[0][28:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s2        <= s_abs * s_abs;
      sq_n[0]   <= (q2e_pkg::SQ_W'(1) << 56) - s2;
      sq_res[0] <= '0;
    end
  end

  // Digit-by-digit square root, one result bit per stage, starting at 2^56.
  for (genvar k = 0; k < q2e_pkg::SQ_STEPS; k++) begin : g_sqrt
    logic [q2e_pkg::SQ_W-1:0] trial;
    assign trial = sq_res[k] + (q2e_pkg::SQ_W'(1) << (56 - 2*k));
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_n[k] >= trial) begin
          sq_n[k+1]   <= sq_n[k] - trial;
          sq_res[k+1] <= (sq_res[k] >> 1) + (q2e_pkg::SQ_W'(1) << (56 - 2*k));
        end else begin
          sq_n[k+1]   <= sq_n[k];
          sq_res[k+1] <= sq_res[k] >> 1;
        end
      end
    end
  end

  // Three CORDIC pipelines side by side.
  q2e_pkg::sum_t pitch_y, pitch_x;
  q2e_pkg::ang_t roll_ang, pitch_ang, yaw_ang;

  assign pitch_y = q2e_pkg::sum_t'(s_d[q2e_pkg::DLY]);
  assign pitch_x = q2e_pkg::sum_t'(signed'({1'b0, sq_res[q2e_pkg::SQ_STEPS][28:0]}));

  q2e_cordic u_roll (
    .clk  (clk),
    .en   (en),
    .y_in (d_rn[q2e_pkg::DLY]),
    .x_in (d_rd[q2e_pkg::DLY]),
    .ang  (roll_ang)
  );

  q2e_cordic u_pitch (
    .clk  (clk),
    .en   (en),
    .y_in (pitch_y),
    .x_in (pitch_x),
    .ang  (pitch_ang)
  );

  q2e_cordic u_yaw (
    .clk  (clk),
    .en   (en),
    .y_in (d_yn[q2e_pkg::DLY]),
    .x_in (d_yd[q2e_pkg::DLY]),
    .ang  (yaw_ang)
  );

  // Rounds half up to 1/128 degree and saturates at the given limit.
  function automatic logic signed [15:0] round_sat(q2e_pkg::ang_t a, logic signed [17:0] lim);
    q2e_pkg::ang_t      t;
    logic signed [17:0] v;
    t = (a + q2e_pkg::ang_t'(1 <<< 15)) >>> 16;
    v = t[17:0];
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  logic signed [15:0] pitch_full;
  assign pitch_full = round_sat(pitch_ang, 18'(q2e_pkg::PITCH_LIM));

  always_ff @(posedge clk) begin
    if (en) begin
      roll_deg  <= round_sat(roll_ang, 18'(q2e_pkg::ROLL_LIM));
      pitch_deg <= pitch_full[14:0];
      yaw_deg   <= round_sat(yaw_ang, 18'(q2e_pkg::ROLL_LIM));
    end
  end

  // Nothing leaves the block in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present straight after reset");

  // Saturation keeps every delivered angle within its range.
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_deg <= 15'sd11520) && (pitch_deg >= -15'sd11520))
    else $error("pitch outside its range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_deg <= 16'sd23040) && (roll_deg >= -16'sd23040)
      && (yaw_deg <= 16'sd23040) && (yaw_deg >= -16'sd23040))
    else $error("roll or yaw outside its range");

  // A waiting result word must not be overwritten while the pipeline stalls; roll and yaw are checked.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(roll_deg) && $stable(yaw_deg))
    else $error("stalled result word changed");

endmodule
